### rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue with bucket drain.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int ID_W        = 16;
  localparam int CLS_W       = 2;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [CLS_W-1:0] CLS_TOP = 2'd3;
  localparam logic [ID_W-1:0]  SAT16   = 16'hFFFF;

  // command codes on the input channel
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DRAIN  = 2'd1,
    MODE_REPORT = 2'd2
  } mode_t;

  // result codes
  typedef enum logic [2:0] {
    KIND_ACCEPT  = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_DRAINED = 3'd2,
    KIND_EMPTY   = 3'd3,
    KIND_REPORT  = 3'd4
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic  latch;   // capture the input beat
    logic  mul;     // register the reciprocal product
    logic  insert;  // write the new entry into the chain
    logic  pop;     // shift the head out of the chain
    logic  emit;    // load the result register
    kind_t kind;
    logic  last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic head_top;  // head entry exists and holds the top class
    logic next_top;  // second entry exists and holds the top class
  } status_t;

endpackage

### rtl/core/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: decodes a command beat, steps an insert through its multiply and
// write states and pops top-class entries one per cycle during a drain.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       in_mode,
  input  spq_pkg::status_t st,
  output spq_pkg::cmd_t    cmd,
  output logic             busy
);
  import spq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS_MUL,
    S_INS_PUT,
    S_DRAIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             head_pop;
  logic             next_pop;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  // the per-command pop limit caps how far a drain runs
  assign head_pop = st.head_top && (cnt_r < CNT_W'(MAX_RESULTS));
  assign next_pop = st.next_top && (cnt_r < CNT_W'(MAX_RESULTS - 1));

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    cmd.kind   = KIND_ACCEPT;
    case (state_r)
      S_IDLE: begin
        cnt_nxt   = '0;
        cmd.latch = accept;
        if (accept) begin
          case (in_mode)
            MODE_INSERT: begin
              if (st.full) begin
                cmd.emit = 1'b1;
                cmd.kind = KIND_FULL;
                cmd.last = 1'b1;
              end else begin
                state_nxt = S_INS_MUL;
              end
            end
            MODE_DRAIN:  state_nxt = S_DRAIN;
            MODE_REPORT: begin
              cmd.emit = 1'b1;
              cmd.kind = KIND_REPORT;
              cmd.last = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_INS_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_INS_PUT;
      end
      S_INS_PUT: begin
        cmd.insert = 1'b1;
        cmd.emit   = 1'b1;
        cmd.kind   = KIND_ACCEPT;
        cmd.last   = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_DRAIN: begin
        cmd.emit = 1'b1;
        if (head_pop) begin
          cmd.pop  = 1'b1;
          cmd.kind = KIND_DRAINED;
          cmd.last = !next_pop;
          cnt_nxt  = cnt_r + CNT_W'(1);
          if (!next_pop) state_nxt = S_IDLE;
        end else begin
          cmd.kind  = KIND_EMPTY;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and pop counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### rtl/core/spq_dpath.sv
// ----------------------------------------------------------------------------
// spq_dpath
// Sorted shifting chain of entries, bucket index unit, bucket occupancy bits,
// collision total and the result register.
// ----------------------------------------------------------------------------
module spq_dpath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int BUCKETS     = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  spq_pkg::cmd_t            cmd,
  input  logic [spq_pkg::ID_W-1:0] in_item_id,
  input  logic                     in_impact_flag,
  input  logic                     in_likely_flag,
  output spq_pkg::status_t         st,
  output logic                     out_valid,
  output logic [2:0]               out_kind,
  output logic [spq_pkg::ID_W-1:0] out_id,
  output logic [3:0]               out_bucket,
  output logic [spq_pkg::ID_W-1:0] out_collisions,
  output logic                     out_last
);
  import spq_pkg::*;

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int BKT_W  = $clog2(BUCKETS);
  // exact reciprocal for a 16-bit dividend: q = (id * MULT) >> SHIFT
  localparam int SHIFT  = ID_W + BKT_W;
  localparam int MUL_W  = ID_W + 2;
  localparam int PROD_W = ID_W + MUL_W;
  localparam logic [MUL_W-1:0] MULT = MUL_W'((2**SHIFT + BUCKETS - 1) / BUCKETS);

  // entry chain, only entries below the fill count are meaningful
  logic [CLS_W-1:0]  q_cls_r [QUEUE_DEPTH];
  logic [ID_W-1:0]   q_id_r  [QUEUE_DEPTH];
  logic [BKT_W-1:0]  q_bkt_r [QUEUE_DEPTH];
  logic [FILL_W-1:0] fill_r;

  // a bucket counter only ever grows, so a collision needs just "seen before"
  logic [BUCKETS-1:0] seen_r;
  logic [ID_W-1:0]    coll_r, coll_nxt;

  logic [ID_W-1:0]   id_r;
  logic [CLS_W-1:0]  cls_r;
  logic [PROD_W-1:0] prod_r;

  logic [ID_W-1:0]   quot;
  logic [ID_W-1:0]   rem;
  logic [BKT_W-1:0]  new_bkt;
  logic [QUEUE_DEPTH-1:0] sel;

  // bucket index of the latched id
  always_comb begin
    quot    = ID_W'(prod_r >> SHIFT);
    rem     = id_r - quot * ID_W'(BUCKETS);
    new_bkt = BKT_W'(rem);
  end

  // per entry: does the new item land at or before this slot
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (FILL_W'(i) < fill_r) begin
        if (cls_r != q_cls_r[i]) sel[i] = (cls_r > q_cls_r[i]);
        else                     sel[i] = (id_r < q_id_r[i]);
      end else begin
        sel[i] = (FILL_W'(i) == fill_r);
      end
    end
  end

  // status toward the sequencer
  always_comb begin
    st.full     = (fill_r == FILL_W'(QUEUE_DEPTH));
    st.head_top = (fill_r != '0) && (q_cls_r[0] == CLS_TOP);
    st.next_top = (fill_r > FILL_W'(1)) && (q_cls_r[1] == CLS_TOP);
  end

  // collision total after a pop
  always_comb begin
    coll_nxt = coll_r;
    if (cmd.pop && seen_r[q_bkt_r[0]] && (coll_r != SAT16)) coll_nxt = coll_r + ID_W'(1);
  end

  // input capture and reciprocal product
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      id_r  <= in_item_id;
      cls_r <= {in_impact_flag, in_likely_flag};
    end
    if (cmd.mul) prod_r <= PROD_W'(id_r) * PROD_W'(MULT);
  end

  // chain insert and shift-out
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd.insert && sel[i]) begin
        if (i > 0 && sel[(i > 0) ? i - 1 : 0]) begin
          q_cls_r[i] <= q_cls_r[(i > 0) ? i - 1 : 0];
          q_id_r[i]  <= q_id_r[(i > 0) ? i - 1 : 0];
          q_bkt_r[i] <= q_bkt_r[(i > 0) ? i - 1 : 0];
        end else begin
          q_cls_r[i] <= cls_r;
          q_id_r[i]  <= id_r;
          q_bkt_r[i] <= new_bkt;
        end
      end else if (cmd.pop && i < QUEUE_DEPTH - 1) begin
        q_cls_r[i] <= q_cls_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        q_id_r[i]  <= q_id_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        q_bkt_r[i] <= q_bkt_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // fill count, bucket occupancy and collision total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      seen_r <= '0;
      coll_r <= '0;
    end else begin
      if (cmd.insert)   fill_r <= fill_r + FILL_W'(1);
      else if (cmd.pop) fill_r <= fill_r - FILL_W'(1);
      if (cmd.pop) seen_r[q_bkt_r[0]] <= 1'b1;
      coll_r <= coll_nxt;
    end
  end

  // result register, one beat per strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
    if (cmd.emit) begin
      out_kind       <= cmd.kind;
      out_collisions <= coll_nxt;
      out_last       <= cmd.last;
      if (cmd.kind == KIND_DRAINED) begin
        out_id     <= q_id_r[0];
        out_bucket <= 4'(q_bkt_r[0]);
      end else begin
        out_id     <= '0;
        out_bucket <= '0;
      end
    end
  end

endmodule

### rtl/core/sorted_priority_queue_with_bucket_drain.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_with_bucket_drain
// Bounded priority queue of ids ranked by a two-flag class, lower id first on
// ties, with a drain of top-class entries and a bucket collision total.
//
//   channel | ports                                      | handshake
//   --------+--------------------------------------------+------------------
//   command | in_mode in_item_id in_impact_flag          | start & !busy
//           | in_likely_flag                             |
//   result  | out_kind out_id out_bucket out_collisions  | out_valid strobe
//           | out_last                                   |
//
// insert: capture, reciprocal multiply for the bucket, then chain write
// drain: one result beat per cycle, one per popped entry or a single empty beat
// report, full reject and unused mode: busy stays low
// synchronous active-low reset empties the queue and clears bucket history
// results are a one-cycle strobe; the receiver cannot hold them off
// ----------------------------------------------------------------------------
module sorted_priority_queue_with_bucket_drain #(
  parameter int QUEUE_DEPTH = 16,
  parameter int BUCKETS     = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_mode,
  input  logic [spq_pkg::ID_W-1:0] in_item_id,
  input  logic                     in_impact_flag,
  input  logic                     in_likely_flag,
  output logic                     out_valid,
  output logic [2:0]               out_kind,
  output logic [spq_pkg::ID_W-1:0] out_id,
  output logic [3:0]               out_bucket,
  output logic [spq_pkg::ID_W-1:0] out_collisions,
  output logic                     out_last
);
  import spq_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencer
  spq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .st      (st),
    .cmd     (cmd),
    .busy    (busy)
  );

  // queue storage and result path
  spq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .BUCKETS     (BUCKETS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_item_id     (in_item_id),
    .in_impact_flag (in_impact_flag),
    .in_likely_flag (in_likely_flag),
    .st             (st),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_id         (out_id),
    .out_bucket     (out_bucket),
    .out_collisions (out_collisions),
    .out_last       (out_last)
  );

endmodule

### rtl/core/spq_chk.sv
// ----------------------------------------------------------------------------
// spq_chk
// Port-level checks on result beats of the priority queue, bound to the top.
// ----------------------------------------------------------------------------
module spq_chk (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic [1:0]               in_mode,
  input logic                     out_valid,
  input logic [2:0]               out_kind,
  input logic [spq_pkg::ID_W-1:0] out_id,
  input logic [3:0]               out_bucket,
  input logic [spq_pkg::ID_W-1:0] out_collisions,
  input logic                     out_last
);
  import spq_pkg::*;

  // every result other than a drained item is a single beat
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_DRAINED) |-> out_last)
    else $error("non-drain result without last");

  // id and bucket are zero unless an item was drained
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_DRAINED) |-> (out_id == '0) && (out_bucket == '0))
    else $error("id or bucket set on a non-drain result");

  // collision total never goes down between back-to-back beats
  a_coll_grows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) |-> out_collisions >= $past(out_collisions))
    else $error("collision total decreased");

  // a report command answers on the very next cycle
  a_report: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_mode == MODE_REPORT) |=> out_valid && (out_kind == KIND_REPORT))
    else $error("report beat missing");

endmodule

bind sorted_priority_queue_with_bucket_drain spq_chk u_spq_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_mode        (in_mode),
  .out_valid      (out_valid),
  .out_kind       (out_kind),
  .out_id         (out_id),
  .out_bucket     (out_bucket),
  .out_collisions (out_collisions),
  .out_last       (out_last)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted priority queue with bucket drain. A
// clocked driver sends insert, drain, report and unused-mode beats in random
// bursts with gaps. A running copy of the queue, the bucket counters and the
// collision total predicts every result row. A clocked monitor compares each
// strobed row with the oldest prediction, field by field. The stimulus is a
// directed opener, random rounds and a short closing sequence.
// ----------------------------------------------------------------------------
module tb_top;
  import spq_pkg::*;

  localparam int Q_DEPTH      = 16;
  localparam int N_BUCKETS    = 10;
  localparam int RANDOM_BEATS = 215;
  localparam int QUIET_LIMIT  = 300;
  localparam int TAIL_CYCLES  = 20;

  // mode value the block ignores
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // class codes built from the two flags
  localparam logic [CLS_W-1:0] CLS_NONE   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_LIKELY = 2'd1;
  localparam logic [CLS_W-1:0] CLS_IMPACT = 2'd2;

  localparam logic [ID_W-1:0] TOP_IDS [Q_DEPTH] = '{
    16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'd7,    16'd7,    16'd17,   16'd27,
    16'h8000, 16'h0001, 16'h7FFF, 16'd100,  16'd110,  16'd120,  16'd5,    16'hFFFF
  };

  typedef struct packed {
    logic [1:0]      mode;
    logic [ID_W-1:0] id;
    logic            impact;
    logic            likely;
  } queue_cmd_t;

  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] id;
    logic [3:0]      bucket;
    logic [ID_W-1:0] collisions;
    logic            last;
  } queue_row_t;

  logic            clk            = 1'b0;
  logic            rst_n          = 1'b0;
  logic            start          = 1'b0;
  logic [1:0]      in_mode        = '0;
  logic [ID_W-1:0] in_item_id     = '0;
  logic            in_impact_flag = 1'b0;
  logic            in_likely_flag = 1'b0;
  logic            busy;
  logic            out_valid;
  logic [2:0]      out_kind;
  logic [ID_W-1:0] out_id;
  logic [3:0]      out_bucket;
  logic [ID_W-1:0] out_collisions;
  logic            out_last;

  // stimulus backlog and predicted result rows
  queue_cmd_t cmd_backlog [$];
  queue_row_t predicted_rows [$];

  // running copy of the queue state
  logic [ID_W-1:0]  mdl_id [Q_DEPTH];
  logic [CLS_W-1:0] mdl_cls [Q_DEPTH];
  int               mdl_fill;
  logic [ID_W-1:0]  mdl_bucket_cnt [N_BUCKETS];
  logic [ID_W-1:0]  mdl_collisions;

  // driver state
  queue_cmd_t cur_cmd  = '0;
  bit         have_cmd = 1'b0;
  int         gap_left   = 0;
  int         burst_left = 1;

  int err_cnt   = 0;
  int quiet_cnt = 0;

  sorted_priority_queue_with_bucket_drain #(
    .QUEUE_DEPTH (Q_DEPTH),
    .BUCKETS     (N_BUCKETS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_item_id     (in_item_id),
    .in_impact_flag (in_impact_flag),
    .in_likely_flag (in_likely_flag),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_id         (out_id),
    .out_bucket     (out_bucket),
    .out_collisions (out_collisions),
    .out_last       (out_last)
  );

  // clock
  always #5 clk = ~clk;

  // push one predicted row carrying the current collision total
  task automatic push_row(input kind_t kind, input logic [ID_W-1:0] id,
                          input logic [3:0] bucket, input logic last);
    queue_row_t row;
    row.kind       = kind;
    row.id         = id;
    row.bucket     = bucket;
    row.collisions = mdl_collisions;
    row.last       = last;
    predicted_rows.push_back(row);
  endtask

  // apply one accepted beat to the queue copy and predict its rows
  task automatic advance_queue_model(input queue_cmd_t cmd);
    logic [CLS_W-1:0] cls;
    int               pos;
    int               n;
    int               i;
    int               bk;
    cls = {cmd.impact, cmd.likely};
    case (cmd.mode)
      MODE_INSERT: begin
        if (mdl_fill >= Q_DEPTH) begin
          push_row(KIND_FULL, '0, '0, 1'b1);
        end else begin
          // skip entries ranking ahead of or equal to the new one
          pos = 0;
          while (pos < mdl_fill && (mdl_cls[pos] > cls ||
                 (mdl_cls[pos] == cls && mdl_id[pos] <= cmd.id)))
            pos++;
          for (i = mdl_fill; i > pos; i--) begin
            mdl_id[i]  = mdl_id[i-1];
            mdl_cls[i] = mdl_cls[i-1];
          end
          mdl_id[pos]  = cmd.id;
          mdl_cls[pos] = cls;
          mdl_fill++;
          push_row(KIND_ACCEPT, '0, '0, 1'b1);
        end
      end
      MODE_DRAIN: begin
        n = 0;
        while (n < mdl_fill && n < MAX_RESULTS && mdl_cls[n] == CLS_TOP)
          n++;
        if (n == 0) begin
          push_row(KIND_EMPTY, '0, '0, 1'b1);
        end else begin
          // pop the top-class run, counting bucket collisions
          for (i = 0; i < n; i++) begin
            bk = mdl_id[i] % N_BUCKETS;
            if (mdl_bucket_cnt[bk] != 0 && mdl_collisions < SAT16)
              mdl_collisions++;
            if (mdl_bucket_cnt[bk] < SAT16)
              mdl_bucket_cnt[bk]++;
            push_row(KIND_DRAINED, mdl_id[i], 4'(bk), i == n - 1);
          end
          for (i = n; i < mdl_fill; i++) begin
            mdl_id[i-n]  = mdl_id[i];
            mdl_cls[i-n] = mdl_cls[i];
          end
          mdl_fill -= n;
        end
      end
      MODE_REPORT: push_row(KIND_REPORT, '0, '0, 1'b1);
      default: ;
    endcase
  endtask

  task automatic push_cmd(input logic [1:0] mode, input logic [ID_W-1:0] id,
                          input logic impact, input logic likely);
    queue_cmd_t cmd;
    cmd.mode   = mode;
    cmd.id     = id;
    cmd.impact = impact;
    cmd.likely = likely;
    cmd_backlog.push_back(cmd);
  endtask

  // wait until every queued beat is accepted and every row has arrived
  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || have_cmd || predicted_rows.size() != 0)
      @(posedge clk);
  endtask

  function automatic void compare_field(input string name, input int want,
                                        input int got);
    if (want != got) begin
      if (err_cnt < 100)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // driver: bursts of beats with random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      start          <= 1'b0;
      in_mode        <= '0;
      in_item_id     <= '0;
      in_impact_flag <= 1'b0;
      in_likely_flag <= 1'b0;
      have_cmd   = 1'b0;
      gap_left   = 0;
      burst_left = 1;
      mdl_fill       = 0;
      mdl_collisions = '0;
      for (int b = 0; b < N_BUCKETS; b++)
        mdl_bucket_cnt[b] = '0;
    end else begin
      if (start && !busy) begin
        advance_queue_model(cur_cmd);
        have_cmd = 1'b0;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else if (gap_left != 0) begin
        gap_left--;
      end
      if (!have_cmd && gap_left == 0 && cmd_backlog.size() != 0) begin
        cur_cmd  = cmd_backlog.pop_front();
        have_cmd = 1'b1;
      end
      start          <= have_cmd;
      in_mode        <= cur_cmd.mode;
      in_item_id     <= cur_cmd.id;
      in_impact_flag <= cur_cmd.impact;
      in_likely_flag <= cur_cmd.likely;
    end
  end

  // monitor: every strobed row against the oldest prediction
  always @(posedge clk) begin
    queue_row_t want;
    if (rst_n && out_valid) begin
      if (predicted_rows.size() == 0) begin
        if (err_cnt < 100)
          $display("%0t: unexpected row, expected none, actual kind %0d id %0d",
                   $time, out_kind, out_id);
        err_cnt++;
      end else begin
        want = predicted_rows.pop_front();
        compare_field("kind", int'(want.kind), int'(out_kind));
        compare_field("id", int'(want.id), int'(out_id));
        compare_field("bucket", int'(want.bucket), int'(out_bucket));
        compare_field("collisions", int'(want.collisions), int'(out_collisions));
        compare_field("last", int'(want.last), int'(out_last));
      end
    end
  end

  // watchdog on cycles with no input beat and no awaited result beat
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || (out_valid && predicted_rows.size() != 0)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // stimulus
  initial begin
    int               n_random;
    int               lows_left;
    int               burst;
    int               pick;
    logic [CLS_W-1:0] cls;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // opener: empty queue, ignored mode, then a full queue of top class
    push_cmd(MODE_REPORT, '0, 1'b0, 1'b0);
    push_cmd(MODE_DRAIN, '0, 1'b0, 1'b0);
    push_cmd(MODE_UNUSED, 16'hFFFF, 1'b1, 1'b1);
    for (int k = 0; k < Q_DEPTH; k++)
      push_cmd(MODE_INSERT, TOP_IDS[k], 1'b1, 1'b1);
    // insert when full, then a drain of the whole queue
    push_cmd(MODE_INSERT, 16'h1234, 1'b1, 1'b1);
    push_cmd(MODE_DRAIN, '0, 1'b0, 1'b0);
    // lower classes stay forever; a drain with one at the head finds nothing
    push_cmd(MODE_INSERT, 16'hFFFF, CLS_NONE[1], CLS_NONE[0]);
    push_cmd(MODE_INSERT, 16'h0000, CLS_LIKELY[1], CLS_LIKELY[0]);
    push_cmd(MODE_INSERT, 16'h5555, CLS_IMPACT[1], CLS_IMPACT[0]);
    push_cmd(MODE_DRAIN, '0, 1'b0, 1'b0);
    push_cmd(MODE_REPORT, '0, 1'b0, 1'b0);

    // random rounds, mostly top-class inserts with a closing drain
    n_random  = 0;
    lows_left = 2;
    while (n_random < RANDOM_BEATS) begin
      burst = $urandom_range(1, 18);
      for (int k = 0; k < burst; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          push_cmd(MODE_INSERT, ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 40))
                                                            : 16'($urandom_range(0, 65535)),
                   1'b1, 1'b1);
          n_random++;
        end else if (pick < 76 && lows_left != 0) begin
          cls = CLS_W'($urandom_range(0, 2));
          push_cmd(MODE_INSERT, 16'($urandom_range(0, 65535)), cls[1], cls[0]);
          lows_left--;
          n_random++;
        end else if (pick < 88) begin
          push_cmd(MODE_DRAIN, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
          n_random++;
        end else if (pick < 96) begin
          push_cmd(MODE_REPORT, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
          n_random++;
        end else begin
          push_cmd(MODE_UNUSED, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        end
      end
      push_cmd(MODE_DRAIN, '0, 1'b0, 1'b0);
      n_random++;
    end

    // closing report, insert and drains
    push_cmd(MODE_REPORT, '0, 1'b0, 1'b0);
    push_cmd(MODE_INSERT, 16'd42, 1'b1, 1'b1);
    push_cmd(MODE_DRAIN, '0, 1'b0, 1'b0);
    push_cmd(MODE_DRAIN, '0, 1'b0, 1'b0);
    push_cmd(MODE_REPORT, '0, 1'b0, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
